@@ sv/sbsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Serial bank switch mapper package
// Shared codes, widths and the bank state record passed to the datapath.
// ----------------------------------------------------------------------------
package sbsm_pkg;

   // Field widths
   localparam int unsigned OP_W     = 2;
   localparam int unsigned ADDR_W   = 16;
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned TGT_W    = 2;
   localparam int unsigned OFFS_W   = 19;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 5;

   // Operation codes
   localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
   localparam logic [OP_W-1:0] OP_PRG_READ = 2'd1;
   localparam logic [OP_W-1:0] OP_CHR_READ = 2'd2;

   // Result targets
   localparam logic [TGT_W-1:0] TGT_NONE = 2'd0;
   localparam logic [TGT_W-1:0] TGT_PRG  = 2'd1;
   localparam logic [TGT_W-1:0] TGT_CHR  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRG_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHR_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_MIRROR = 2'd2;

   // Serial register target, address bits 14..13
   localparam logic [1:0] SEL_CONTROL = 2'd0;
   localparam logic [1:0] SEL_CHR_LOW = 2'd1;
   localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
   localparam logic [1:0] SEL_PRG     = 2'd3;

   // PRG banking modes, control bits 3..2
   localparam logic [1:0] PRG_MODE_SWAP_LOW  = 2'd2;
   localparam logic [1:0] PRG_MODE_SWAP_HIGH = 2'd3;

   localparam logic [2:0] SHIFT_LAST = 3'd4;
   localparam logic [4:0] PRG_COUNT_RESET = 5'd16;
   localparam logic [OFFS_W-1:0] HDR_BYTES = 19'h00010;

   // Bank and configuration state seen by the offset datapath
   typedef struct packed {
      logic [4:0] control;
      logic [4:0] chr_low_bank;
      logic [4:0] chr_high_bank;
      logic [4:0] chr_whole_bank;
      logic [2:0] prg_whole_bank;
      logic [3:0] prg_low_bank;
      logic [3:0] prg_high_bank;
      logic [4:0] prg_bank_count;
      logic [4:0] chr_bank_count;
   } bank_state_type;

   // Bank state after reset: all clear but the program bank count
   localparam bank_state_type BANK_STATE_RESET = '{
      control:        5'd0,
      chr_low_bank:   5'd0,
      chr_high_bank:  5'd0,
      chr_whole_bank: 5'd0,
      prg_whole_bank: 3'd0,
      prg_low_bank:   4'd0,
      prg_high_bank:  4'd0,
      prg_bank_count: PRG_COUNT_RESET,
      chr_bank_count: 5'd0
   };

endpackage

@@ sv/serial_bank_switch_mapper_core.sv @@
// ----------------------------------------------------------------------------
// Serial bank switch mapper core
// Cartridge bank mapper turning bus accesses into cartridge image offsets.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one bus access: a mapper register write, a program read
//          or a character read. A transfer happens when req_valid is high
//          and req_stall is low.
//   rsp_*  carries one result per access: the memory target, the byte offset
//          into the image (header included) and the mirroring flag after the
//          access. A transfer happens when rsp_valid is high and rsp_stall low.
//   csr_*  writes the bank counts and the initial mirroring flag; csr_ready
//          is always high. Write it only while no access is in flight.
// The result is valid in the cycle after the request transfer. While no result
// is stalled, one access is taken every cycle: the bank registers update and
// the offset is formed in the same cycle; a single result register holds it.
// When the receiver stalls a valid result, req_stall rises and the result
// holds until taken; the next request enters in the cycle it is taken.
// Reset clears the serial register, the bank registers, the mirroring flag
// and the result valid flag, and sets the program bank count to sixteen.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sbsm_pkg::OP_W-1:0]        req_operation,
   input  logic [sbsm_pkg::ADDR_W-1:0]      req_address,
   input  logic [sbsm_pkg::DATA_W-1:0]      req_write_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sbsm_pkg::TGT_W-1:0]       rsp_target,
   output logic [sbsm_pkg::OFFS_W-1:0]      rsp_image_offset,
   output logic                             rsp_mirror_flag,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sbsm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sbsm_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import sbsm_pkg::*;

   bank_state_type     bank;
   logic               mirror_next;
   logic               req_xfer;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TGT_W-1:0]   target_ff, target_in;
   logic [OFFS_W-1:0]  offset_ff, offset_in;
   logic               mirror_ff;
   logic [17:0]        prg_rel;
   logic [16:0]        chr_rel;
   logic [OFFS_W-1:0]  chr_base;
   logic [3:0]         prg_bank;
   logic [4:0]         chr_bank;

   // Accept whenever the result register is empty or being drained
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   sbsm_bank_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (req_xfer && (req_operation == OP_WRITE)),
      .wr_address  (req_address),
      .wr_data     (req_write_data),
      .csr_we      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .state       (bank),
      .mirror_next (mirror_next)
   );

   // Form program and character offsets from the current banks
   always_comb begin
      prg_bank = req_address[14] ? bank.prg_high_bank : bank.prg_low_bank;
      if (bank.control[3]) begin
         prg_rel = {prg_bank, req_address[13:0]};
      end else begin
         prg_rel = {bank.prg_whole_bank, req_address[14:0]};
      end

      chr_bank = req_address[12] ? bank.chr_high_bank : bank.chr_low_bank;
      if (bank.control[4]) begin
         chr_rel = {chr_bank, req_address[11:0]};
      end else begin
         chr_rel = {bank.chr_whole_bank[4:1], req_address[12:0]};
      end
      chr_base = {bank.prg_bank_count, 14'd0};
   end

   // Select the result
   always_comb begin
      target_in = TGT_NONE;
      offset_in = '0;
      priority if (req_operation == OP_PRG_READ && req_address[15]) begin
         target_in = TGT_PRG;
         offset_in = HDR_BYTES + OFFS_W'(prg_rel);
      end else if (req_operation == OP_CHR_READ && bank.chr_bank_count != '0
                   && req_address[15:13] == 3'd0) begin
         target_in = TGT_CHR;
         offset_in = HDR_BYTES + chr_base + OFFS_W'(chr_rel);
      end else begin
         target_in = TGT_NONE;
      end
   end

   // Result register valid: load on transfer, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded only on request transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         target_ff <= target_in;
         offset_ff <= offset_in;
         mirror_ff <= mirror_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target       = target_ff;
   assign rsp_image_offset = offset_ff;
   assign rsp_mirror_flag  = mirror_ff;

endmodule

@@ sv/sbsm_bank_regs.sv @@
// ----------------------------------------------------------------------------
// Serial bank switch mapper bank registers
// Serial load register, control and bank registers, configuration and mirror.
// ----------------------------------------------------------------------------
module sbsm_bank_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [sbsm_pkg::ADDR_W-1:0]      wr_address,
   input  logic [sbsm_pkg::DATA_W-1:0]      wr_data,
   input  logic                             csr_we,
   input  logic [sbsm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sbsm_pkg::CSR_DAT_W-1:0]   csr_wdata,
   output sbsm_pkg::bank_state_type         state,
   output logic                             mirror_next
);
   import sbsm_pkg::*;

   logic [4:0]     shift_value_ff, shift_value_in;
   logic [2:0]     shift_count_ff, shift_count_in;
   bank_state_type bank_ff, bank_in;
   logic           init_mirror_ff, init_mirror_in;
   logic           mirror_ff, mirror_in;
   logic [4:0]     shifted;
   logic           mapper_write;

   assign mapper_write = wr_en && wr_address[15];
   assign shifted      = {wr_data[0], shift_value_ff[4:1]};

   // Serial load, commit on the fifth bit, then configuration writes
   always_comb begin
      shift_value_in = shift_value_ff;
      shift_count_in = shift_count_ff;
      bank_in        = bank_ff;
      init_mirror_in = init_mirror_ff;
      mirror_in      = mirror_ff;

      if (mapper_write) begin
         if (wr_data[7]) begin
            shift_value_in  = '0;
            shift_count_in  = '0;
            bank_in.control = '0;
         end else if (shift_count_ff >= SHIFT_LAST) begin
            shift_value_in = '0;
            shift_count_in = '0;
            unique case (wr_address[14:13])
               SEL_CONTROL: begin
                  bank_in.control = shifted;
                  mirror_in       = shifted[1] & shifted[0];
               end
               SEL_CHR_LOW: begin
                  if (bank_ff.control[4]) begin
                     bank_in.chr_low_bank = shifted;
                  end else begin
                     bank_in.chr_whole_bank = {shifted[4:1], 1'b0};
                  end
               end
               SEL_CHR_HIGH: begin
                  if (bank_ff.control[4]) begin
                     bank_in.chr_high_bank = shifted;
                  end
               end
               SEL_PRG: begin
                  unique case (bank_ff.control[3:2])
                     PRG_MODE_SWAP_LOW: begin
                        bank_in.prg_low_bank  = '0;
                        bank_in.prg_high_bank = shifted[3:0];
                     end
                     PRG_MODE_SWAP_HIGH: begin
                        bank_in.prg_low_bank  = shifted[3:0];
                        bank_in.prg_high_bank = 4'(bank_ff.prg_bank_count - 5'd1);
                     end
                     default: begin
                        bank_in.prg_whole_bank = shifted[3:1];
                     end
                  endcase
               end
               default: begin
                  bank_in = bank_ff;
               end
            endcase
         end else begin
            shift_value_in = shifted;
            shift_count_in = shift_count_ff + 3'd1;
         end
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_PRG_COUNT:   bank_in.prg_bank_count = csr_wdata;
            CSR_CHR_COUNT:   bank_in.chr_bank_count = csr_wdata;
            CSR_INIT_MIRROR: begin
               init_mirror_in = csr_wdata[0];
               mirror_in      = csr_wdata[0];
            end
            default: begin
               init_mirror_in = init_mirror_ff;
            end
         endcase
      end
   end

   // Hold state; reset clears it but sets the program bank count to sixteen
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_value_ff <= '0;
         shift_count_ff <= '0;
         bank_ff        <= BANK_STATE_RESET;
         init_mirror_ff <= 1'b0;
         mirror_ff      <= 1'b0;
      end else begin
         shift_value_ff <= shift_value_in;
         shift_count_ff <= shift_count_in;
         bank_ff        <= bank_in;
         init_mirror_ff <= init_mirror_in;
         mirror_ff      <= mirror_in;
      end
   end

   assign state       = bank_ff;
   assign mirror_next = mirror_in;

endmodule

@@ sv/sbsm_checker.sv @@
// ----------------------------------------------------------------------------
// Serial bank switch mapper checker
// Port-level checks on result timing and result contents.
// ----------------------------------------------------------------------------
module sbsm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [sbsm_pkg::OP_W-1:0]        req_operation,
   input logic [sbsm_pkg::ADDR_W-1:0]      req_address,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [sbsm_pkg::TGT_W-1:0]       rsp_target,
   input logic [sbsm_pkg::OFFS_W-1:0]      rsp_image_offset
);
   import sbsm_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_image_offset)
                                 && $stable(rsp_target))
      else $error("stalled result changed");

   // Every request transfer yields a result in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("result missing one cycle after request");

   // Register writes never access memory
   a_write_none: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_operation == OP_WRITE
      |=> rsp_target == TGT_NONE && rsp_image_offset == '0)
      else $error("register write produced a memory access");

   // Program reads below program space give no access
   a_prg_low: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_operation == OP_PRG_READ && !req_address[15]
      |=> rsp_target == TGT_NONE)
      else $error("program read below program space accessed memory");

endmodule

bind serial_bank_switch_mapper_core sbsm_checker u_sbsm_checker (.*);

@@ verif/tb_serial_bank_switch_mapper_core.sv @@
// ----------------------------------------------------------------------------
// Serial bank switch mapper core testbench
// Drives register writes, program reads and character reads through the
// request channel and checks every result against a cycle-free predictor of
// the serial register, the bank registers and the offset arithmetic. A short
// directed table comes first. Random phases follow, each with its own bank
// counts and mirroring flag and one of four sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_serial_bank_switch_mapper_core;
   import sbsm_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
   localparam logic [15:0]     PRG_BASE      = 16'h8000;
   localparam logic [15:0]     PRG_HIGH_BASE = 16'hC000;
   localparam int unsigned     PRG_HALF      = 32'h4000;
   localparam int unsigned     PRG_SPAN      = 32'h8000;
   localparam int unsigned     CHR_UNIT      = 32'h1000;
   localparam int unsigned     CHR_SPAN      = 32'h2000;
   localparam int unsigned     PHASES        = 8;
   localparam int unsigned     PHASE_ITEMS   = 56;
   localparam int unsigned     DRAIN_LIMIT   = 2000;
   localparam int unsigned     ROWS          = 27;

   typedef struct packed {
      logic [TGT_W-1:0]  target;
      logic [OFFS_W-1:0] offset;
      logic              mirror;
   } bus_result_type;

   typedef enum logic {ROW_ACC, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [OP_W-1:0]        op;
      logic [ADDR_W-1:0]      addr;
      logic [DATA_W-1:0]      data;
      logic [CSR_IDX_W-1:0]   csr_idx;
      logic [CSR_DAT_W-1:0]   csr_val;
      logic                   has_lit;
      bus_result_type         lit;
   } directed_row_type;

   // Directed accesses; rows with has_lit set carry the result by hand
   directed_row_type directed_rows [ROWS] = '{
      '{ROW_ACC, OP_PRG_READ, 16'h8000, 8'h00, CSR_PRG_COUNT, 5'd0, 1'b1,
        '{TGT_PRG, 19'h00010, 1'b0}},
      '{ROW_ACC, OP_PRG_READ, 16'hFFFF, 8'h00, CSR_PRG_COUNT, 5'd0, 1'b1,
        '{TGT_PRG, 19'h0800F, 1'b0}},
      // read below program space
      '{ROW_ACC, OP_PRG_READ, 16'h7FFF, 8'hFF, CSR_PRG_COUNT, 5'd0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0}},
      // character read with no character ROM
      '{ROW_ACC, OP_CHR_READ, 16'h0000, 8'h00, CSR_PRG_COUNT, 5'd0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0}},
      '{ROW_ACC, OP_UNUSED, 16'hFFFF, 8'hFF, CSR_PRG_COUNT, 5'd0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0}},
      // write below the register window is dropped
      '{ROW_ACC, OP_WRITE, 16'h7FFF, 8'h01, CSR_PRG_COUNT, 5'd0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0}},
      // reset bit
      '{ROW_ACC, OP_WRITE, 16'h8000, 8'h80, CSR_PRG_COUNT, 5'd0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0}},
      // serial load of control 5'h1F: 4 KB character banks, swap-high PRG mode
      '{ROW_ACC, OP_WRITE, 16'h8000, 8'h7F, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      '{ROW_ACC, OP_WRITE, 16'h8000, 8'h7F, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      '{ROW_ACC, OP_WRITE, 16'hFFFF, 8'h7F, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      '{ROW_ACC, OP_WRITE, 16'h8000, 8'h7F, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      '{ROW_ACC, OP_WRITE, 16'h9FFF, 8'h7F, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      '{ROW_CSR, OP_WRITE, 16'h0000, 8'h00, CSR_CHR_COUNT, 5'd16, 1'b0, '0},
      // serial load of PRG bank 4'hF
      '{ROW_ACC, OP_WRITE, 16'hE000, 8'h01, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      '{ROW_ACC, OP_WRITE, 16'h8001, 8'h41, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      '{ROW_ACC, OP_WRITE, 16'hC000, 8'h21, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      '{ROW_ACC, OP_WRITE, 16'hA000, 8'h11, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      '{ROW_ACC, OP_WRITE, 16'hFFFF, 8'h7E, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      '{ROW_ACC, OP_PRG_READ, 16'hBFFF, 8'h00, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      '{ROW_ACC, OP_PRG_READ, 16'hC000, 8'h00, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      '{ROW_ACC, OP_CHR_READ, 16'h0FFF, 8'h00, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      '{ROW_ACC, OP_CHR_READ, 16'h1FFF, 8'h00, CSR_PRG_COUNT, 5'd0, 1'b0, '0},
      // character read beyond pattern space
      '{ROW_ACC, OP_CHR_READ, 16'h2000, 8'h00, CSR_PRG_COUNT, 5'd0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b1}},
      // initial mirror write reloads the flag
      '{ROW_CSR, OP_WRITE, 16'h0000, 8'h00, CSR_INIT_MIRROR, 5'd0, 1'b0, '0},
      '{ROW_ACC, OP_WRITE, 16'hFFFF, 8'hFF, CSR_PRG_COUNT, 5'd0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0}},
      '{ROW_ACC, OP_PRG_READ, 16'hFFFF, 8'h00, CSR_PRG_COUNT, 5'd0, 1'b1,
        '{TGT_PRG, 19'h0800F, 1'b0}},
      '{ROW_ACC, OP_CHR_READ, 16'hFFFF, 8'hFF, CSR_PRG_COUNT, 5'd0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0}}
   };

   // Bank counts and mirroring flag for the fixed random phases
   localparam logic [4:0] PHASE_PRG [4] = '{5'd16, 5'd1, 5'd1, 5'd16};
   localparam logic [4:0] PHASE_CHR [4] = '{5'd16, 5'd0, 5'd16, 5'd1};
   localparam logic       PHASE_MIR [4] = '{1'b1, 1'b0, 1'b1, 1'b0};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_operation = OP_WRITE;
   logic [ADDR_W-1:0]     req_address = '0;
   logic [DATA_W-1:0]     req_write_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [TGT_W-1:0]      rsp_target;
   logic [OFFS_W-1:0]     rsp_image_offset;
   logic                  rsp_mirror_flag;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_PRG_COUNT;
   logic [CSR_DAT_W-1:0]  csr_wdata = '0;

   // Predicted mapper state
   logic [4:0] cfg_prg_banks = PRG_COUNT_RESET;
   logic [4:0] cfg_chr_banks = 5'd0;
   logic [4:0] serial_bits = '0;
   logic [2:0] serial_count = '0;
   logic [4:0] ctrl_reg = '0;
   logic [4:0] chr_lo_bank = '0;
   logic [4:0] chr_hi_bank = '0;
   logic [4:0] chr_8k_bank = '0;
   logic [2:0] prg_32k_bank = '0;
   logic [3:0] prg_lo_bank = '0;
   logic [3:0] prg_hi_bank = '0;
   logic       mirror_now = 1'b0;

   bus_result_type pending_results [$];
   int unsigned req_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned accesses_sent = 0;
   int unsigned results_checked = 0;
   int unsigned settings_used = 1;
   int unsigned mismatches = 0;

   serial_bank_switch_mapper_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_target       (rsp_target),
      .rsp_image_offset (rsp_image_offset),
      .rsp_mirror_flag  (rsp_mirror_flag),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // Advance the mapper state by one access and form its result
   function automatic bus_result_type map_access(input logic [OP_W-1:0] op,
                                                 input logic [ADDR_W-1:0] addr,
                                                 input logic [DATA_W-1:0] data);
      bus_result_type res;
      logic [4:0]  v;
      int unsigned rel;
      int unsigned sum;
      res.target = TGT_NONE;
      res.offset = '0;
      sum = 0;
      case (op)
         OP_WRITE: begin
            if (addr >= PRG_BASE) begin
               if (data[7]) begin
                  serial_bits = '0;
                  serial_count = '0;
                  ctrl_reg = '0;
               end else begin
                  serial_bits = {data[0], serial_bits[4:1]};
                  if (serial_count != SHIFT_LAST) begin
                     serial_count = serial_count + 3'd1;
                  end else begin
                     // fifth bit: address bits 14..13 pick the register
                     v = serial_bits;
                     case (addr[14:13])
                        SEL_CONTROL: begin
                           ctrl_reg = v;
                           mirror_now = (v[1:0] == 2'b11);
                        end
                        SEL_CHR_LOW: begin
                           if (ctrl_reg[4]) chr_lo_bank = v;
                           else chr_8k_bank = {v[4:1], 1'b0};
                        end
                        SEL_CHR_HIGH: begin
                           if (ctrl_reg[4]) chr_hi_bank = v;
                        end
                        SEL_PRG: begin
                           if (!ctrl_reg[3]) begin
                              prg_32k_bank = v[3:1];
                           end else if (ctrl_reg[3:2] == PRG_MODE_SWAP_LOW) begin
                              prg_lo_bank = '0;
                              prg_hi_bank = v[3:0];
                           end else begin
                              prg_lo_bank = v[3:0];
                              prg_hi_bank = cfg_prg_banks[3:0] - 4'd1;
                           end
                        end
                     endcase
                     serial_bits = '0;
                     serial_count = '0;
                  end
               end
            end
         end
         OP_PRG_READ: begin
            if (addr >= PRG_BASE) begin
               if (ctrl_reg[3])
                  rel = 32'(addr < PRG_HIGH_BASE ? prg_lo_bank : prg_hi_bank) * PRG_HALF
                        + 32'(addr[13:0]);
               else
                  rel = 32'(prg_32k_bank) * PRG_SPAN + 32'(addr[14:0]);
               res.target = TGT_PRG;
               sum = 32'(HDR_BYTES) + rel;
            end
         end
         OP_CHR_READ: begin
            if (cfg_chr_banks != 5'd0 && 32'(addr) < CHR_SPAN) begin
               if (ctrl_reg[4])
                  rel = 32'(32'(addr) < CHR_UNIT ? chr_lo_bank : chr_hi_bank) * CHR_UNIT
                        + 32'(addr[11:0]);
               else
                  rel = 32'(chr_8k_bank) * CHR_UNIT + 32'(addr[12:0]);
               res.target = TGT_CHR;
               sum = 32'(HDR_BYTES) + 32'(cfg_prg_banks) * PRG_HALF + rel;
            end
         end
         default: ;
      endcase
      res.offset = sum[OFFS_W-1:0];
      res.mirror = mirror_now;
      return res;
   endfunction

   // One request transfer; hold the payload while stalled
   task automatic send_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data, input logic has_lit,
                              input bus_result_type lit);
      bus_result_type want;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_address <= addr;
      req_write_data <= data;
      do @(posedge clock); while (req_stall);
      want = map_access(op, addr, data);
      if (has_lit) want = lit;
      pending_results.push_back(want);
      accesses_sent++;
   endtask

   // Drop the request and wait until no result is outstanding
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PRG_COUNT: cfg_prg_banks = val;
         CSR_CHR_COUNT: cfg_chr_banks = val;
         CSR_INIT_MIRROR: mirror_now = val[0];
         default: ;
      endcase
   endtask

   // Mostly complete serial loads with random bits, plus reads and noise
   task automatic drive_random_accesses(input int unsigned count);
      int unsigned done_n;
      int unsigned pick;
      logic [1:0]  region;
      logic [15:0] addr;
      done_n = 0;
      while (done_n < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            region = 2'($urandom_range(0, 3));
            for (int b = 0; b <= int'(SHIFT_LAST); b++) begin
               addr = (b == int'(SHIFT_LAST)) ? {1'b1, region, 13'($urandom)}
                                              : {1'b1, 15'($urandom)};
               send_access(OP_WRITE, addr, {1'b0, 7'($urandom)}, 1'b0, '0);
            end
            done_n += 5;
         end else if (pick < 75) begin
            if ($urandom_range(0, 1) == 1) begin
               send_access(OP_PRG_READ, 16'($urandom), 8'($urandom), 1'b0, '0);
            end else begin
               addr = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, CHR_SPAN - 1));
               send_access(OP_CHR_READ, addr, 8'($urandom), 1'b0, '0);
            end
            done_n++;
         end else begin
            send_access(2'($urandom), 16'($urandom), 8'($urandom), 1'b0, '0);
            done_n++;
         end
      end
   endtask

   // Result checker and receiver stall
   always @(posedge clock) begin
      bus_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with none expected", 32'(rsp_image_offset), 0);
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (rsp_target !== want.target)
                  report_mismatch("target", 32'(rsp_target), 32'(want.target));
               if (rsp_image_offset !== want.offset)
                  report_mismatch("image offset", 32'(rsp_image_offset),
                                  32'(want.offset));
               if (rsp_mirror_flag !== want.mirror)
                  report_mismatch("mirror flag", 32'(rsp_mirror_flag), 32'(want.mirror));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   initial begin
      int unsigned waited;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            settle_idle();
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_val);
         end else begin
            send_access(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                        directed_rows[i].has_lit, directed_rows[i].lit);
         end
      end

      // Random phases: new bank counts, then one idle pattern each
      for (int phase = 0; phase < PHASES; phase++) begin
         settle_idle();
         if (phase < 4) begin
            write_csr(CSR_PRG_COUNT, PHASE_PRG[phase]);
            write_csr(CSR_CHR_COUNT, PHASE_CHR[phase]);
            write_csr(CSR_INIT_MIRROR, {4'd0, PHASE_MIR[phase]});
         end else begin
            write_csr(CSR_PRG_COUNT, 5'($urandom_range(1, 16)));
            write_csr(CSR_CHR_COUNT, 5'($urandom_range(0, 16)));
            write_csr(CSR_INIT_MIRROR, 5'($urandom_range(0, 1)));
         end
         settings_used++;
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 51; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 51; end
            default: begin req_idle_pct = 7; rsp_stall_pct = 7; end
         endcase
         drive_random_accesses(PHASE_ITEMS);
      end

      // Drain outstanding results
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", pending_results.size(), 0);

      $display("Sent %0d accesses (%0d directed) across %0d bank settings and four idle patterns",
               accesses_sent, ROWS - 2, settings_used);
      $display("Checked %0d results, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0)
         $display("tb_serial_bank_switch_mapper_core passed");
      else
         $display("tb_serial_bank_switch_mapper_core failed");
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("tb_serial_bank_switch_mapper_core failed");
      $finish;
   end

endmodule
